FILE: rtl/core/sgc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgc_pkg
// Shared types and constants for the stick gesture confirm sequencer.
// ----------------------------------------------------------------------------
package sgc_pkg;

  // field widths
  localparam int PULSE_W   = 12;
  localparam int DZ_W      = 10;
  localparam int MS_W      = 16;
  localparam int ELAPSED_W = 17;
  localparam int PHASE_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CONFIRM  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_RELEASE  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_TIMEOUT  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_FINISHED = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THR_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STR_TARGET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RETURN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CONF_HOLD   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REL_HOLD    = 3'd7;

  // register reset values
  localparam logic [PULSE_W-1:0] RST_THR_TARGET = 12'd2000;
  localparam logic [PULSE_W-1:0] RST_STR_TARGET = 12'd2000;
  localparam logic [PULSE_W-1:0] RST_CENTER     = 12'd1500;
  localparam logic [DZ_W-1:0]    RST_DEADZONE   = 10'd100;
  localparam logic [MS_W-1:0]    RST_TIMEOUT    = 16'd10000;
  localparam logic [MS_W-1:0]    RST_RETURN     = 16'd2000;
  localparam logic [MS_W-1:0]    RST_CONF_HOLD  = 16'd1000;
  localparam logic [MS_W-1:0]    RST_REL_HOLD   = 16'd500;

  // counter ceilings
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
  localparam logic [MS_W-1:0]      HOLD_MAX    = {MS_W{1'b1}};

  typedef struct packed {
    logic               restart;
    logic [PULSE_W-1:0] throttle_pulse;
    logic [PULSE_W-1:0] steering_pulse;
  } tick_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               done_res;
    logic               confirmed;
  } status_t;

  // pulse within deadzone of target
  function automatic logic near_target(input logic [PULSE_W-1:0] target,
                                       input logic [PULSE_W-1:0] pulse,
                                       input logic [DZ_W-1:0]    dz);
    logic [PULSE_W-1:0] diff;
    diff = (target >= pulse) ? (target - pulse) : (pulse - target);
    return diff <= {{(PULSE_W-DZ_W){1'b0}}, dz};
  endfunction

endpackage

FILE: rtl/core/stick_gesture_confirm_fsm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stick_gesture_confirm_fsm_core
// Stick gesture confirmation sequencer: one status result per input tick.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | request   | in_valid / in_stall | in_data  (sgc_pkg::tick_t)
//  out     | result    | out_valid/out_stall | out_data (sgc_pkg::status_t)
//  cfg     | write     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  one request per cycle unless in_stall; result registered the next cycle
//  the window compare and counter update are combinational ahead of the state register
//  rst (synchronous) returns the phase to idle and restores register defaults
//  in_stall rises only when the output register is full and out_stall is high
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module stick_gesture_confirm_fsm_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sgc_pkg::tick_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sgc_pkg::status_t                    out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sgc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sgc_pkg::CFG_DAT_W-1:0]       cfg_data
);

  // configuration registers
  logic [sgc_pkg::PULSE_W-1:0] thr_target;
  logic [sgc_pkg::PULSE_W-1:0] str_target;
  logic [sgc_pkg::PULSE_W-1:0] center;
  logic [sgc_pkg::DZ_W-1:0]    deadzone;
  logic [sgc_pkg::MS_W-1:0]    timeout_ms;
  logic [sgc_pkg::MS_W-1:0]    return_ms;
  logic [sgc_pkg::MS_W-1:0]    conf_hold_ms;
  logic [sgc_pkg::MS_W-1:0]    rel_hold_ms;

  // sequencer state
  logic [sgc_pkg::PHASE_W-1:0]   phase_reg, phase_reg_next;
  logic [sgc_pkg::ELAPSED_W-1:0] elapsed, elapsed_next;
  logic                          hold_active, hold_active_next;
  logic [sgc_pkg::MS_W-1:0]      hold_ticks, hold_ticks_next;
  logic                          confirmed_flag, confirmed_flag_next;

  logic                          in_accept;
  logic [sgc_pkg::ELAPSED_W-1:0] elapsed_inc;
  logic [sgc_pkg::ELAPSED_W-1:0] return_limit;
  logic [sgc_pkg::MS_W-1:0]      hold_inc;
  logic                          win_confirm;
  logic                          win_center;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_target   <= sgc_pkg::RST_THR_TARGET;
      str_target   <= sgc_pkg::RST_STR_TARGET;
      center       <= sgc_pkg::RST_CENTER;
      deadzone     <= sgc_pkg::RST_DEADZONE;
      timeout_ms   <= sgc_pkg::RST_TIMEOUT;
      return_ms    <= sgc_pkg::RST_RETURN;
      conf_hold_ms <= sgc_pkg::RST_CONF_HOLD;
      rel_hold_ms  <= sgc_pkg::RST_REL_HOLD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sgc_pkg::REG_THR_TARGET: thr_target   <= cfg_data[sgc_pkg::PULSE_W-1:0];
        sgc_pkg::REG_STR_TARGET: str_target   <= cfg_data[sgc_pkg::PULSE_W-1:0];
        sgc_pkg::REG_CENTER:     center       <= cfg_data[sgc_pkg::PULSE_W-1:0];
        sgc_pkg::REG_DEADZONE:   deadzone     <= cfg_data[sgc_pkg::DZ_W-1:0];
        sgc_pkg::REG_TIMEOUT:    timeout_ms   <= cfg_data;
        sgc_pkg::REG_RETURN:     return_ms    <= cfg_data;
        sgc_pkg::REG_CONF_HOLD:  conf_hold_ms <= cfg_data;
        sgc_pkg::REG_REL_HOLD:   rel_hold_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturating counters and window checks
  assign elapsed_inc  = (elapsed == sgc_pkg::ELAPSED_MAX) ? elapsed
                                                          : elapsed + 1'b1;
  assign hold_inc     = (hold_ticks == sgc_pkg::HOLD_MAX) ? hold_ticks
                                                          : hold_ticks + 1'b1;
  // sum of two 16-bit values never exceeds the 17-bit ceiling
  assign return_limit = {1'b0, timeout_ms} + {1'b0, return_ms};
  assign win_confirm  = sgc_pkg::near_target(thr_target, in_data.throttle_pulse, deadzone)
                     && sgc_pkg::near_target(str_target, in_data.steering_pulse, deadzone);
  assign win_center   = sgc_pkg::near_target(center, in_data.throttle_pulse, deadzone)
                     && sgc_pkg::near_target(center, in_data.steering_pulse, deadzone);

  // next state for one tick
  always_comb begin
    phase_reg_next      = phase_reg;
    elapsed_next        = elapsed;
    hold_active_next    = hold_active;
    hold_ticks_next     = hold_ticks;
    confirmed_flag_next = confirmed_flag;
    if (in_data.restart) begin
      phase_reg_next      = sgc_pkg::PH_CONFIRM;
      elapsed_next        = '0;
      hold_active_next    = 1'b0;
      hold_ticks_next     = '0;
      confirmed_flag_next = 1'b0;
    end else begin
      unique case (phase_reg)
        sgc_pkg::PH_CONFIRM: begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc >= {1'b0, timeout_ms}) begin
            phase_reg_next = sgc_pkg::PH_TIMEOUT;
          end else if (!win_confirm) begin
            hold_active_next = 1'b0;
            hold_ticks_next  = '0;
          end else if (!hold_active) begin
            hold_active_next = 1'b1;
            hold_ticks_next  = '0;
          end else if (hold_inc >= conf_hold_ms) begin
            phase_reg_next   = sgc_pkg::PH_RELEASE;
            hold_active_next = 1'b0;
            hold_ticks_next  = '0;
          end else begin
            hold_ticks_next = hold_inc;
          end
        end
        sgc_pkg::PH_RELEASE: begin
          elapsed_next = elapsed_inc;
          if (!win_center) begin
            hold_active_next = 1'b0;
            hold_ticks_next  = '0;
          end else if (!hold_active) begin
            hold_active_next = 1'b1;
            hold_ticks_next  = '0;
          end else if (hold_inc >= rel_hold_ms) begin
            phase_reg_next      = sgc_pkg::PH_FINISHED;
            confirmed_flag_next = 1'b1;
            hold_active_next    = 1'b0;
            hold_ticks_next     = '0;
          end else begin
            hold_ticks_next = hold_inc;
          end
        end
        sgc_pkg::PH_TIMEOUT: begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc >= return_limit) begin
            phase_reg_next      = sgc_pkg::PH_FINISHED;
            confirmed_flag_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // state update on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg      <= sgc_pkg::PH_IDLE;
      elapsed        <= '0;
      hold_active    <= 1'b0;
      hold_ticks     <= '0;
      confirmed_flag <= 1'b0;
    end else if (in_accept) begin
      phase_reg      <= phase_reg_next;
      elapsed        <= elapsed_next;
      hold_active    <= hold_active_next;
      hold_ticks     <= hold_ticks_next;
      confirmed_flag <= confirmed_flag_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data.phase     <= phase_reg_next;
      out_data.done_res  <= (phase_reg_next == sgc_pkg::PH_FINISHED);
      out_data.confirmed <= (phase_reg_next == sgc_pkg::PH_FINISHED)
                            && confirmed_flag_next;
    end
  end

`ifndef SYNTH
  // done flag follows the finished phase
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.done_res == (out_data.phase == sgc_pkg::PH_FINISHED)))
    else $error("done flag disagrees with phase");

  // confirmed only once finished
  a_conf_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.confirmed |-> out_data.done_res)
    else $error("confirmed without done");

  // restart puts the sequence back at the start of confirm
  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_data.restart |=> phase_reg == sgc_pkg::PH_CONFIRM
      && elapsed == '0 && !hold_active && !confirmed_flag)
    else $error("restart did not clear the sequence");

  // hold count only runs while a hold is active
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !hold_active |-> hold_ticks == '0)
    else $error("hold count without active hold");
`endif

endmodule

FILE: test/tb_stick_gesture_confirm_fsm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stick_gesture_confirm_fsm_core
// Self-checking bench for the stick gesture confirm sequencer. A short table
// of directed ticks covers idle, sticky finish, zero holds, zero timeout,
// deadzone edges and pulse extremes; randomised gesture sequences follow under
// a range of register settings, with random gaps on the request side and
// random stalls on the result side. Each result is checked field by field
// against its table entry or a behavioural model of the sequencer in the bench.
// ----------------------------------------------------------------------------
module tb_stick_gesture_confirm_fsm_core;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  sgc_pkg::tick_t                in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  sgc_pkg::status_t              out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [sgc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sgc_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  stick_gesture_confirm_fsm_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register mirror
  logic [sgc_pkg::PULSE_W-1:0] thr_target   = sgc_pkg::RST_THR_TARGET;
  logic [sgc_pkg::PULSE_W-1:0] str_target   = sgc_pkg::RST_STR_TARGET;
  logic [sgc_pkg::PULSE_W-1:0] center_pos   = sgc_pkg::RST_CENTER;
  logic [sgc_pkg::DZ_W-1:0]    dz_width     = sgc_pkg::RST_DEADZONE;
  logic [sgc_pkg::MS_W-1:0]    timeout_ms   = sgc_pkg::RST_TIMEOUT;
  logic [sgc_pkg::MS_W-1:0]    return_ms    = sgc_pkg::RST_RETURN;
  logic [sgc_pkg::MS_W-1:0]    confirm_hold = sgc_pkg::RST_CONF_HOLD;
  logic [sgc_pkg::MS_W-1:0]    release_hold = sgc_pkg::RST_REL_HOLD;

  // sequencer state mirror
  logic [sgc_pkg::PHASE_W-1:0]   cur_phase     = sgc_pkg::PH_IDLE;
  logic [sgc_pkg::ELAPSED_W-1:0] elapsed_cnt   = '0;
  bit                            hold_on       = 1'b0;
  logic [sgc_pkg::MS_W-1:0]      hold_cnt      = '0;
  bit                            confirmed_reg = 1'b0;

  sgc_pkg::status_t status_expected[$];
  int               fail_count = 0;
  bit               quiet      = 1'b0;
  bit               clean_run  = 1'b1;
  int               stall_left = 0;

  typedef struct {
    bit               is_write;
    logic [2:0]       idx;
    logic [15:0]      val;
    sgc_pkg::tick_t   tk;
    bit               typed;
    sgc_pkg::status_t want;
  } dir_step_t;

  dir_step_t dir_steps[$];

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endfunction

  // pulse within deadzone of target
  function automatic bit in_band(int target, int pulse);
    int diff;
    diff = (target >= pulse) ? target - pulse : pulse - target;
    return diff <= int'(dz_width);
  endfunction

  // hold counter step, 1 when the hold time is met
  function automatic bit hold_advance(bit win, logic [sgc_pkg::MS_W-1:0] need);
    if (!win) begin
      hold_on  = 1'b0;
      hold_cnt = '0;
      return 1'b0;
    end
    if (!hold_on) begin
      hold_on  = 1'b1;
      hold_cnt = '0;
      return 1'b0;
    end
    if (hold_cnt != sgc_pkg::HOLD_MAX) hold_cnt++;
    return hold_cnt >= need;
  endfunction

  // one tick of the sequencer, returns the status after it
  function automatic sgc_pkg::status_t advance_sequencer(sgc_pkg::tick_t t);
    sgc_pkg::status_t s;
    bit               win;
    int               lim;
    if (t.restart) begin
      cur_phase     = sgc_pkg::PH_CONFIRM;
      elapsed_cnt   = '0;
      hold_on       = 1'b0;
      hold_cnt      = '0;
      confirmed_reg = 1'b0;
    end else if (cur_phase == sgc_pkg::PH_CONFIRM || cur_phase == sgc_pkg::PH_RELEASE ||
                 cur_phase == sgc_pkg::PH_TIMEOUT) begin
      if (elapsed_cnt != sgc_pkg::ELAPSED_MAX) elapsed_cnt++;
      if (cur_phase == sgc_pkg::PH_CONFIRM) begin
        if (elapsed_cnt >= {1'b0, timeout_ms}) begin
          cur_phase = sgc_pkg::PH_TIMEOUT;
        end else begin
          win = in_band(int'(thr_target), int'(t.throttle_pulse)) &&
                in_band(int'(str_target), int'(t.steering_pulse));
          if (hold_advance(win, confirm_hold)) begin
            cur_phase = sgc_pkg::PH_RELEASE;
            hold_on   = 1'b0;
            hold_cnt  = '0;
          end
        end
      end else if (cur_phase == sgc_pkg::PH_RELEASE) begin
        win = in_band(int'(center_pos), int'(t.throttle_pulse)) &&
              in_band(int'(center_pos), int'(t.steering_pulse));
        if (hold_advance(win, release_hold)) begin
          cur_phase     = sgc_pkg::PH_FINISHED;
          confirmed_reg = 1'b1;
          hold_on       = 1'b0;
          hold_cnt      = '0;
        end
      end else begin
        lim = int'(timeout_ms) + int'(return_ms);
        if (lim > int'(sgc_pkg::ELAPSED_MAX)) lim = int'(sgc_pkg::ELAPSED_MAX);
        if (int'(elapsed_cnt) >= lim) begin
          cur_phase     = sgc_pkg::PH_FINISHED;
          confirmed_reg = 1'b0;
        end
      end
    end
    s.phase     = cur_phase;
    s.done_res  = (cur_phase == sgc_pkg::PH_FINISHED);
    s.confirmed = (cur_phase == sgc_pkg::PH_FINISHED) && confirmed_reg;
    return s;
  endfunction

  function automatic sgc_pkg::status_t mk_status(logic [sgc_pkg::PHASE_W-1:0] ph,
                                                 bit dn, bit cf);
    sgc_pkg::status_t s;
    s.phase     = ph;
    s.done_res  = dn;
    s.confirmed = cf;
    return s;
  endfunction

  function automatic void add_tick(bit rs, int thr, int str, bit typed,
                                   logic [sgc_pkg::PHASE_W-1:0] ph, bit dn, bit cf);
    dir_step_t d;
    d.is_write = 1'b0;
    d.idx      = '0;
    d.val      = '0;
    d.tk.restart        = rs;
    d.tk.throttle_pulse = thr[sgc_pkg::PULSE_W-1:0];
    d.tk.steering_pulse = str[sgc_pkg::PULSE_W-1:0];
    d.typed    = typed;
    d.want     = mk_status(ph, dn, cf);
    dir_steps.push_back(d);
  endfunction

  function automatic void add_write(logic [2:0] idx, int val);
    dir_step_t d;
    d          = '{default: '0};
    d.is_write = 1'b1;
    d.idx      = idx;
    d.val      = val[15:0];
    dir_steps.push_back(d);
  endfunction

  // gap length before a request, mostly short
  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // pulse near a target; noisy runs also step outside the deadzone
  function automatic logic [sgc_pkg::PULSE_W-1:0] pick_pulse(int target);
    int r, off, v;
    r = $urandom_range(0, 99);
    if (!clean_run && r >= 85) begin
      v = $urandom_range(0, 4095);
      return v[sgc_pkg::PULSE_W-1:0];
    end
    if (!clean_run && r >= 70) off = int'(dz_width) + $urandom_range(0, 1);
    else off = $urandom_range(0, int'(dz_width));
    v = ($urandom_range(0, 1) != 0) ? target + off : target - off;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[sgc_pkg::PULSE_W-1:0];
  endfunction

  // next gesture tick based on the current phase
  function automatic sgc_pkg::tick_t next_tick();
    sgc_pkg::tick_t t;
    int             r;
    r = $urandom_range(0, 99);
    if (cur_phase == sgc_pkg::PH_IDLE || cur_phase == sgc_pkg::PH_FINISHED)
      t.restart = (r < 35);
    else t.restart = (r < 2);
    if (t.restart) clean_run = ($urandom_range(0, 99) < 60);
    if (cur_phase == sgc_pkg::PH_RELEASE && !t.restart) begin
      t.throttle_pulse = pick_pulse(int'(center_pos));
      t.steering_pulse = pick_pulse(int'(center_pos));
    end else begin
      t.throttle_pulse = pick_pulse(int'(thr_target));
      t.steering_pulse = pick_pulse(int'(str_target));
    end
    return t;
  endfunction

  // send one request and record its expected status
  task automatic send_tick(sgc_pkg::tick_t t, bit typed, sgc_pkg::status_t want);
    int               n;
    sgc_pkg::status_t s;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!(in_valid && !in_stall));
    s = advance_sequencer(t);
    status_expected.push_back(typed ? want : s);
  endtask

  // hold off requests until every status is back
  task automatic drain();
    in_valid <= 1'b0;
    while (status_expected.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // register write, leaves cfg_valid high for a following write
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      sgc_pkg::REG_THR_TARGET: thr_target   = val[sgc_pkg::PULSE_W-1:0];
      sgc_pkg::REG_STR_TARGET: str_target   = val[sgc_pkg::PULSE_W-1:0];
      sgc_pkg::REG_CENTER:     center_pos   = val[sgc_pkg::PULSE_W-1:0];
      sgc_pkg::REG_DEADZONE:   dz_width     = val[sgc_pkg::DZ_W-1:0];
      sgc_pkg::REG_TIMEOUT:    timeout_ms   = val;
      sgc_pkg::REG_RETURN:     return_ms    = val;
      sgc_pkg::REG_CONF_HOLD:  confirm_hold = val;
      default:                 release_hold = val;
    endcase
  endtask

  // register set for one random stretch: all ones, all zeros or short timers
  task automatic program_config(int ph);
    logic [15:0] v [8];
    int          r;
    if (ph == 0) begin
      foreach (v[i]) v[i] = 16'hFFFF;
    end else if (ph == 1) begin
      foreach (v[i]) v[i] = 16'h0000;
    end else begin
      // spare upper bits on the targets, the center and the deadzone edge values are random
      v[sgc_pkg::REG_THR_TARGET] = {4'($urandom), 12'($urandom)};
      v[sgc_pkg::REG_STR_TARGET] = {4'($urandom), 12'($urandom)};
      v[sgc_pkg::REG_CENTER]     = {4'($urandom), 12'($urandom)};
      r = $urandom_range(0, 99);
      if (r < 10) v[sgc_pkg::REG_DEADZONE] = {6'($urandom), 10'd0};
      else if (r < 20) v[sgc_pkg::REG_DEADZONE] = {6'($urandom), 10'd1023};
      else v[sgc_pkg::REG_DEADZONE] = 16'($urandom_range(1, 200));
      v[sgc_pkg::REG_TIMEOUT]    = ($urandom_range(0, 99) < 15)
                                   ? 16'($urandom_range(0, 3))
                                   : 16'($urandom_range(10, 80));
      v[sgc_pkg::REG_RETURN]     = 16'($urandom_range(0, 25));
      v[sgc_pkg::REG_CONF_HOLD]  = 16'($urandom_range(0, 12));
      v[sgc_pkg::REG_REL_HOLD]   = 16'($urandom_range(0, 12));
    end
    foreach (v[i]) write_reg(3'(i), v[i]);
    cfg_valid <= 1'b0;
  endtask

  // result side stalls: short bursts, a few long ones
  always @(posedge clk) begin
    int r;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (quiet || r < 70) begin
        out_stall <= 1'b0;
      end else if (r < 95) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(5, 25);
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    sgc_pkg::status_t want;
    if (!rst && out_valid && !out_stall) begin
      if (status_expected.size() == 0) begin
        note_failure($sformatf("unexpected status: phase %0d done %0d conf %0d",
                               out_data.phase, out_data.done_res, out_data.confirmed));
      end else begin
        want = status_expected.pop_front();
        if (out_data.phase !== want.phase)
          note_failure($sformatf("phase mismatch: expected %0d got %0d",
                                 want.phase, out_data.phase));
        if (out_data.done_res !== want.done_res)
          note_failure($sformatf("done_res mismatch: expected %0d got %0d",
                                 want.done_res, out_data.done_res));
        if (out_data.confirmed !== want.confirmed)
          note_failure($sformatf("confirmed mismatch: expected %0d got %0d",
                                 want.confirmed, out_data.confirmed));
      end
    end
  end

  // stimulus
  initial begin
    int             w;
    sgc_pkg::tick_t t;
    dir_step_t      d;

    // reset defaults: idle ignores ticks, restart enters confirm
    add_tick(0, 0, 0, 1, sgc_pkg::PH_IDLE, 0, 0);
    add_tick(0, 4095, 4095, 1, sgc_pkg::PH_IDLE, 0, 0);
    add_tick(1, 2000, 2000, 1, sgc_pkg::PH_CONFIRM, 0, 0);
    add_tick(0, 0, 4095, 1, sgc_pkg::PH_CONFIRM, 0, 0);
    // deadzone edge and one past it
    add_tick(0, 2100, 1900, 0, sgc_pkg::PH_IDLE, 0, 0);
    add_tick(0, 2101, 2000, 0, sgc_pkg::PH_IDLE, 0, 0);
    // zero holds, zero deadzone, targets at the pulse extremes
    add_write(sgc_pkg::REG_THR_TARGET, 4095);
    add_write(sgc_pkg::REG_STR_TARGET, 0);
    add_write(sgc_pkg::REG_CENTER, 0);
    add_write(sgc_pkg::REG_DEADZONE, 0);
    add_write(sgc_pkg::REG_TIMEOUT, 5);
    add_write(sgc_pkg::REG_RETURN, 3);
    add_write(sgc_pkg::REG_CONF_HOLD, 0);
    add_write(sgc_pkg::REG_REL_HOLD, 0);
    add_tick(1, 4095, 0, 1, sgc_pkg::PH_CONFIRM, 0, 0);
    add_tick(0, 4095, 0, 0, sgc_pkg::PH_IDLE, 0, 0);
    add_tick(0, 4095, 0, 0, sgc_pkg::PH_IDLE, 0, 0);
    add_tick(0, 0, 0, 0, sgc_pkg::PH_IDLE, 0, 0);
    add_tick(0, 0, 0, 0, sgc_pkg::PH_IDLE, 0, 0);
    // finished is sticky until a restart
    add_tick(0, 123, 456, 1, sgc_pkg::PH_FINISHED, 1, 1);
    // confirm runs out, timeout phase ends unconfirmed
    add_tick(1, 4095, 0, 1, sgc_pkg::PH_CONFIRM, 0, 0);
    add_tick(0, 4094, 0, 0, sgc_pkg::PH_IDLE, 0, 0);
    add_tick(0, 4094, 0, 0, sgc_pkg::PH_IDLE, 0, 0);
    add_tick(0, 4094, 0, 0, sgc_pkg::PH_IDLE, 0, 0);
    add_tick(0, 4095, 1, 0, sgc_pkg::PH_IDLE, 0, 0);
    add_tick(0, 4095, 0, 0, sgc_pkg::PH_IDLE, 0, 0);
    add_tick(0, 4095, 0, 0, sgc_pkg::PH_IDLE, 0, 0);
    add_tick(0, 4095, 0, 0, sgc_pkg::PH_IDLE, 0, 0);
    add_tick(0, 4095, 0, 0, sgc_pkg::PH_IDLE, 0, 0);
    // zero timeout: timeout on the first ordinary tick
    add_write(sgc_pkg::REG_TIMEOUT, 0);
    add_write(sgc_pkg::REG_RETURN, 0);
    add_write(sgc_pkg::REG_DEADZONE, 1023);
    add_tick(1, 4095, 0, 1, sgc_pkg::PH_CONFIRM, 0, 0);
    add_tick(0, 4095, 0, 1, sgc_pkg::PH_TIMEOUT, 0, 0);
    add_tick(0, 4095, 0, 1, sgc_pkg::PH_FINISHED, 1, 0);
    add_tick(0, 2048, 2048, 1, sgc_pkg::PH_FINISHED, 1, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_steps[i]) begin
      d = dir_steps[i];
      if (d.is_write) begin
        if (i == 0 || !dir_steps[i-1].is_write) drain();
        write_reg(d.idx, d.val);
        if (i == dir_steps.size() - 1 || !dir_steps[i+1].is_write) cfg_valid <= 1'b0;
      end else begin
        send_tick(d.tk, d.typed, d.want);
      end
    end

    // random gesture sequences under changing settings
    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph % 4 == 3);
      drain();
      program_config(ph);
      for (int k = 0; k < 120; k++) begin
        if (ph == 5 && k == 60) drain();
        t = next_tick();
        send_tick(t, 1'b0, mk_status(sgc_pkg::PH_IDLE, 0, 0));
      end
    end

    in_valid <= 1'b0;
    w = 0;
    while (status_expected.size() != 0 && w < 1000) begin
      @(posedge clk);
      w++;
    end
    repeat (5) @(posedge clk);
    if (status_expected.size() != 0)
      note_failure($sformatf("%0d expected statuses never arrived",
                             status_expected.size()));
    if (fail_count == 0) begin
      $display("stick_gesture_confirm_fsm_core regression: pass");
    end else begin
      $display("stick_gesture_confirm_fsm_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("stick_gesture_confirm_fsm_core regression: fail");
    $finish;
  end

endmodule
